@@ rtl/core/swec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window event counter package
// Widths, ring geometry, ring command codes and the command type shared by
// the top level, the presence ring and the channel interfaces.
// ----------------------------------------------------------------------------
package swec_pkg;

   // Field widths
   localparam int TS_W  = 32;
   localparam int WIN_W = 12;
   localparam int CNT_W = 13;

   // Presence ring geometry; the depth is a power of two so a slot is the
   // low bits of a timestamp
   localparam int RING_DEPTH = 4096;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int SPAN_MAX   = RING_DEPTH - 1;

   // Window length after reset
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3000);

   // Ring commands: wipe (init pass), clear an expired slot, mark a new event
   typedef enum logic [1:0] {
      RING_WIPE  = 2'd0,
      RING_CLEAR = 2'd1,
      RING_MARK  = 2'd2
   } ring_op_type;

   typedef struct packed {
      logic              en;
      ring_op_type       op;
      logic [SLOT_W-1:0] slot;
   } ring_cmd_type;

endpackage : swec_pkg
`default_nettype wire

@@ rtl/core/swec_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one event timestamp per transaction.
// ----------------------------------------------------------------------------
interface swec_req_if
   import swec_pkg::*;
   ;
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output timestamp, input ready);
   modport sink   (input valid, input timestamp, output ready);
endinterface : swec_req_if
`default_nettype wire

@@ rtl/core/swec_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the window count and the reject flag.
// ----------------------------------------------------------------------------
interface swec_rsp_if
   import swec_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] event_count;
   logic             rejected;

   modport source (output valid, output event_count, output rejected, input ready);
   modport sink   (input valid, input event_count, input rejected, output ready);
endinterface : swec_rsp_if
`default_nettype wire

@@ rtl/core/sliding_window_event_counter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window event counter
// Counts events in the window [timestamp - window_length, timestamp].
// ----------------------------------------------------------------------------
// After reset the block wipes every slot of the presence ring and holds req
// ready low; csr writes are taken during that time. Each request then runs
// one at a time through a small sequencer around one ring port and 32-bit
// compare/subtract logic: an accepted timestamp passes CHECK, PLAN, BOUND,
// SWEEP (N expired ring slots cleared, one per cycle, then the event marked)
// and SETTLE, which registers its response. The window start only advances,
// so no slot time is swept twice, and N is at most 4096. A timestamp that does
// not exceed the last counted one gets the unchanged count with rejected set
// from CHECK. A new request is taken once the previous response is consumed.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_top
   import swec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   swec_req_if.sink              req_bus,
   swec_rsp_if.source            rsp_bus,
   input  wire logic             csr_wr_en,
   input  wire logic [WIN_W-1:0] csr_wr_data
);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_PLAN   = 7'b0001000,
      ST_BOUND  = 7'b0010000,
      ST_SWEEP  = 7'b0100000,
      ST_SETTLE = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [WIN_W-1:0]   wl_ff;
   logic [TS_W-1:0]    ts_ff, ts_in;
   logic [TS_W-1:0]    cand_ff, cand_in;
   logic [TS_W-1:0]    start_ff, start_in;
   logic [TS_W-1:0]    end_ff, end_in;
   logic [TS_W-1:0]    cur_ff, cur_in;
   logic [TS_W-1:0]    ws_ff, ws_in;
   logic [TS_W-1:0]    last_ff, last_in;
   logic               have_ff, have_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_rej_ff, rsp_rej_in;
   logic [TS_W-1:0]    span;
   logic               req_fire;
   ring_cmd_type       ring_cmd;
   logic [CNT_W-1:0]   live_count;
   logic [CNT_W-1:0]   live_count_nx;

   // Effective window span, limited by the ring depth
   assign span = (TS_W'(wl_ff) > TS_W'(SPAN_MAX)) ? TS_W'(SPAN_MAX) : TS_W'(wl_ff);

   assign req_bus.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      ts_in        = ts_ff;
      cand_in      = cand_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      ws_in        = ws_ff;
      last_in      = last_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      rsp_rej_in   = rsp_rej_ff;
      ring_cmd     = '{en: 1'b0, op: RING_WIPE, slot: '0};

      case (state_ff)
         ST_INIT: begin
            // Wipe one ring slot per cycle
            ring_cmd    = '{en: 1'b1, op: RING_WIPE, slot: init_cnt_ff};
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == SLOT_W'(SPAN_MAX)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               ts_in    = req_bus.timestamp;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Reject a non-increasing timestamp, else form the raw window start
            if (have_ff && (ts_ff <= last_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = live_count;
               rsp_rej_in   = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cand_in  = (ts_ff < span) ? '0 : ts_ff - span;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            // Never move the window start backwards
            start_in = (cand_ff < ws_ff) ? ws_ff : cand_ff;
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            // Stop the sweep after the last stored event
            if (!have_ff) begin
               end_in = ws_ff;
            end else if (start_ff <= last_ff) begin
               end_in = start_ff;
            end else begin
               end_in = last_ff + 1'b1;
            end
            cur_in   = ws_ff;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (cur_ff < end_ff) begin
               // Drop one expired slot
               ring_cmd = '{en: 1'b1, op: RING_CLEAR, slot: cur_ff[SLOT_W-1:0]};
               cur_in   = cur_ff + 1'b1;
            end else begin
               // Mark the new event and advance the window
               ring_cmd = '{en: 1'b1, op: RING_MARK, slot: ts_ff[SLOT_W-1:0]};
               ws_in    = start_ff;
               last_in  = ts_ff;
               have_in  = 1'b1;
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = live_count_nx;
            rsp_rej_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         ws_ff        <= '0;
         last_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         ws_ff        <= ws_in;
         last_ff      <= last_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and response payload
   always_ff @(posedge clock) begin
      ts_ff        <= ts_in;
      cand_ff      <= cand_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      cur_ff       <= cur_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         wl_ff <= csr_wr_data;
      end
   end

   swec_ring u_ring (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ring_cmd),
      .live_count    (live_count),
      .live_count_nx (live_count_nx)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.event_count = rsp_count_ff;
   assign rsp_bus.rejected    = rsp_rej_ff;

   // Checks
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (cur_ff <= end_ff))
      else $error("sweep cursor passed its end");

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_bus.ready)
      else $error("request taken while a response is pending");

   a_rsp_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == live_count))
      else $error("response count differs from live count");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && have_ff) |->
         ((ws_ff <= last_ff) &&
          ((33'(last_ff) - 33'(ws_ff)) < 33'(RING_DEPTH))))
      else $error("window start and last timestamp out of order");

endmodule : sliding_window_event_counter_top
`default_nettype wire

@@ rtl/core/swec_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Presence ring
// One bit per timestamp slot with read-modify-write commands, plus the live
// event count that tracks the number of set bits.
// ----------------------------------------------------------------------------
module swec_ring
   import swec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ring_cmd_type     cmd,
   output logic [CNT_W-1:0]      live_count,
   output logic [CNT_W-1:0]      live_count_nx
);

   logic                  ring_mem [RING_DEPTH];
   logic                  rd_bit_ff;
   logic                  pend_en_ff;
   ring_op_type           pend_op_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   // Read the old bit and write the new one at the same slot
   always_ff @(posedge clock) begin
      if (cmd.en) begin
         rd_bit_ff          <= ring_mem[cmd.slot];
         ring_mem[cmd.slot] <= (cmd.op == RING_MARK);
      end
   end

   // Remember which command the read bit belongs to
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_en_ff <= 1'b0;
         pend_op_ff <= RING_WIPE;
      end else begin
         pend_en_ff <= cmd.en;
         pend_op_ff <= cmd.op;
      end
   end

   // Adjust the count from the registered command and the old bit it read
   always_comb begin
      count_in = count_ff;
      if (pend_en_ff) begin
         case (pend_op_ff)
            RING_CLEAR: begin
               if (rd_bit_ff && (count_ff != '0)) count_in = count_ff - 1'b1;
            end
            RING_MARK: begin
               if (!rd_bit_ff && (count_ff != '1)) count_in = count_ff + 1'b1;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign live_count    = count_ff;
   assign live_count_nx = count_in;

endmodule : swec_ring
`default_nettype wire
